[design/collision_neighbor_priority_table_top_defines.svh]
// Assertion macros for the neighbor priority table RTL.
// Needs signals named clock and reset in the module that uses them.
`ifndef COLLISION_NEIGHBOR_PRIORITY_TABLE_TOP_DEFINES_SVH
`define COLLISION_NEIGHBOR_PRIORITY_TABLE_TOP_DEFINES_SVH

// same-cycle implication
`define CNPT_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CNPT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/cnpt_pkg.sv]
// Shared constants, command codes and controller/datapath structs
// for the neighbor priority table. No dependencies.
package cnpt_pkg;

   localparam int ID_W     = 16;
   localparam int MASS_W   = 16;
   localparam int AREA_W   = 32;
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 2;

   localparam int NEIGHBOUR_DEPTH_DEF = 16;
   localparam int MET_DEPTH_DEF       = 16;
   localparam int COORD_BITS_DEF      = 16;

   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_MET    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_PICK   = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NB_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_MET_FULL = 2'd2;

   typedef struct packed {
      logic capture;
      logic do_clear;
      logic do_load;
      logic do_met;
      logic upd_init;
      logic pick_init;
      logic ent_rd;
      logic geo;
      logic mul;
      logic upd_eval;
      logic pick_eval;
      logic upd_fin;
      logic met_init;
      logic met_rd;
      logic met_cmp;
      logic pick_take;
      logic rm_init;
      logic rm_rd;
      logic rm_wr;
      logic rm_fin;
      logic rsp_load;
   } cnpt_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] req_cmd;
      logic             scan_end;
      logic             met_end;
      logic             rm_end;
      logic             nb_empty;
      logic             picked;
      logic             rsp_busy;
   } cnpt_sts_type;

endpackage

[design/cnpt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cnpt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/cnpt_ctrl.sv]
// Sequencer for the neighbor priority table: steps the datapath through
// each command. Depends on cnpt_pkg.
module cnpt_ctrl
   import cnpt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  cnpt_sts_type sts,
   output cnpt_cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_EXEC,
      S_U_CHK, S_U_GEO, S_U_MUL, S_U_EVAL,
      S_P_CHK, S_P_GEO, S_P_MUL, S_P_EVAL,
      S_M_CHK, S_M_CMP, S_TAKE,
      S_R_CHK, S_R_WR, S_P_NEXT,
      S_FIN
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_FIN;
            unique case (sts.req_cmd)
               CMD_CLEAR:  cmd.do_clear = 1'b1;
               CMD_LOAD:   cmd.do_load  = 1'b1;
               CMD_MET:    cmd.do_met   = 1'b1;
               CMD_UPDATE: begin
                  cmd.upd_init = 1'b1;
                  state_in     = S_U_CHK;
               end
               CMD_PICK: begin
                  if (!sts.nb_empty) begin
                     cmd.pick_init = 1'b1;
                     state_in      = S_P_CHK;
                  end
               end
               default: state_in = S_FIN;
            endcase
         end
         S_U_CHK: begin
            if (sts.scan_end) begin
               cmd.upd_fin = 1'b1;
               state_in    = S_FIN;
            end else begin
               cmd.ent_rd = 1'b1;
               state_in   = S_U_GEO;
            end
         end
         S_U_GEO: begin
            cmd.geo  = 1'b1;
            state_in = S_U_MUL;
         end
         S_U_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_U_EVAL;
         end
         S_U_EVAL: begin
            cmd.upd_eval = 1'b1;
            state_in     = S_U_CHK;
         end
         S_P_CHK: begin
            if (sts.scan_end) begin
               cmd.met_init = 1'b1;
               state_in     = S_M_CHK;
            end else begin
               cmd.ent_rd = 1'b1;
               state_in   = S_P_GEO;
            end
         end
         S_P_GEO: begin
            cmd.geo  = 1'b1;
            state_in = S_P_MUL;
         end
         S_P_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_P_EVAL;
         end
         S_P_EVAL: begin
            cmd.pick_eval = 1'b1;
            state_in      = S_P_CHK;
         end
         S_M_CHK: begin
            if (sts.met_end) begin
               state_in = S_TAKE;
            end else begin
               cmd.met_rd = 1'b1;
               state_in   = S_M_CMP;
            end
         end
         S_M_CMP: begin
            cmd.met_cmp = 1'b1;
            state_in    = S_M_CHK;
         end
         S_TAKE: begin
            cmd.pick_take = 1'b1;
            cmd.rm_init   = 1'b1;
            state_in      = S_R_CHK;
         end
         S_R_CHK: begin
            if (sts.rm_end) begin
               cmd.rm_fin = 1'b1;
               state_in   = S_P_NEXT;
            end else begin
               cmd.rm_rd = 1'b1;
               state_in  = S_R_WR;
            end
         end
         S_R_WR: begin
            cmd.rm_wr = 1'b1;
            state_in  = S_R_CHK;
         end
         S_P_NEXT: begin
            if (sts.picked || sts.nb_empty) begin
               state_in = S_FIN;
            end else begin
               cmd.pick_init = 1'b1;
               state_in      = S_P_CHK;
            end
         end
         S_FIN: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

[design/cnpt_dp.sv]
// Datapath of the neighbor priority table: request and result registers,
// counters, overlap area unit, both RAMs. Depends on cnpt_pkg, cnpt_ram.
`include "collision_neighbor_priority_table_top_defines.svh"
module cnpt_dp
   import cnpt_pkg::*;
#(
   parameter int NEIGHBOUR_DEPTH = NEIGHBOUR_DEPTH_DEF,
   parameter int MET_DEPTH       = MET_DEPTH_DEF,
   parameter int COORD_BITS      = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cnpt_cmd_type                 cmd,
   output cnpt_sts_type                 sts,
   input  logic [CMD_W-1:0]             req_command,
   input  logic [ID_W-1:0]              req_item_id,
   input  logic [MASS_W-1:0]            req_mass,
   input  logic signed [COORD_BITS-1:0] req_box_left,
   input  logic signed [COORD_BITS-1:0] req_box_bottom,
   input  logic signed [COORD_BITS-1:0] req_box_right,
   input  logic signed [COORD_BITS-1:0] req_box_top,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [ID_W-1:0]              rsp_picked_id,
   output logic                         rsp_picked_valid,
   output logic [MASS_W-1:0]            rsp_best_mass,
   output logic [AREA_W-1:0]            rsp_best_area,
   output logic                         rsp_any_left,
   output logic [STATUS_W-1:0]          rsp_status
);

   localparam int NB_AW  = $clog2(NEIGHBOUR_DEPTH);
   localparam int NB_CW  = $clog2(NEIGHBOUR_DEPTH + 1);
   localparam int MET_AW = $clog2(MET_DEPTH);
   localparam int MET_CW = $clog2(MET_DEPTH + 1);
   localparam int CB     = COORD_BITS;
   localparam int ENT_W  = ID_W + MASS_W + 4 * CB;
   localparam int PROD_W = 2 * CB;

   // request
   logic [CMD_W-1:0]     req_cmd_ff;
   logic [ID_W-1:0]      req_id_ff;
   logic [MASS_W-1:0]    req_mass_ff;
   logic signed [CB-1:0] own_l_ff, own_b_ff, own_r_ff, own_t_ff;

   // table control
   logic [NB_CW-1:0]  nb_count_ff, idx_ff, keep_ff, scan_best_ff;
   logic [MET_CW-1:0] met_count_ff, met_idx_ff;
   logic              found_ff;

   // area unit
   logic [CB-1:0]     w_ff, h_ff, w_in, h_in;
   logic              ovl_zero_ff, ovl_zero_in;
   logic [AREA_W-1:0] area_ff, area_in;

   // results
   logic [MASS_W-1:0]   best_mass_ff, scan_mass_ff;
   logic [AREA_W-1:0]   best_area_ff, scan_area_ff;
   logic [ID_W-1:0]     scan_id_ff, picked_id_ff;
   logic                picked_valid_ff;
   logic [STATUS_W-1:0] status_ff;

   logic                rsp_valid_ff, rsp_picked_valid_ff, rsp_any_left_ff;
   logic [ID_W-1:0]     rsp_picked_id_ff;
   logic [MASS_W-1:0]   rsp_best_mass_ff;
   logic [AREA_W-1:0]   rsp_best_area_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   // RAM ports
   logic              nb_wr_en;
   logic [NB_AW-1:0]  nb_wr_addr, nb_rd_addr;
   logic [ENT_W-1:0]  nb_wr_data, nb_rdata;
   logic              met_wr_en;
   logic [ID_W-1:0]   met_rdata;

   logic nb_full, met_full, area_nz, better, rsp_busy;
   logic [NB_CW-1:0] idx_next;

   logic [ID_W-1:0]      ent_id;
   logic [MASS_W-1:0]    ent_mass;
   logic signed [CB-1:0] ent_l, ent_b, ent_r, ent_t;
   logic signed [CB-1:0] lo_x, hi_x, lo_y, hi_y;
   logic signed [CB:0]   dx, dy;
   logic [PROD_W-1:0]    prod;
   logic [63:0]          prod_ext;

   assign ent_id   = nb_rdata[ENT_W-1 -: ID_W];
   assign ent_mass = nb_rdata[ENT_W-ID_W-1 -: MASS_W];
   assign ent_l    = nb_rdata[4*CB-1 -: CB];
   assign ent_b    = nb_rdata[3*CB-1 -: CB];
   assign ent_r    = nb_rdata[2*CB-1 -: CB];
   assign ent_t    = nb_rdata[CB-1:0];

   // overlap extents, then width and height
   always_comb begin
      lo_x = (ent_l > own_l_ff) ? ent_l : own_l_ff;
      hi_x = (ent_r < own_r_ff) ? ent_r : own_r_ff;
      lo_y = (ent_b > own_b_ff) ? ent_b : own_b_ff;
      hi_y = (ent_t < own_t_ff) ? ent_t : own_t_ff;
      dx   = {hi_x[CB-1], hi_x} - {lo_x[CB-1], lo_x};
      dy   = {hi_y[CB-1], hi_y} - {lo_y[CB-1], lo_y};
      ovl_zero_in = dx[CB] || (dx == '0) || dy[CB] || (dy == '0);
      w_in = dx[CB-1:0];
      h_in = dy[CB-1:0];
   end

   // product saturates at the area width
   assign prod     = PROD_W'(w_ff) * PROD_W'(h_ff);
   assign prod_ext = 64'(prod);
   assign area_in  = ovl_zero_ff ? '0 :
                     ((|prod_ext[63:AREA_W]) ? '1 : prod_ext[AREA_W-1:0]);

   assign nb_full  = (nb_count_ff == NB_CW'(NEIGHBOUR_DEPTH));
   assign met_full = (met_count_ff == MET_CW'(MET_DEPTH));
   assign area_nz  = (area_ff != '0);
   assign idx_next = idx_ff + 1'b1;
   assign better   = (idx_ff == '0) || (ent_mass > scan_mass_ff) ||
                     ((ent_mass == scan_mass_ff) && (area_ff > scan_area_ff));
   assign rsp_busy = rsp_valid_ff && rsp_stall;

   always_comb begin
      nb_wr_en   = 1'b0;
      nb_wr_addr = idx_ff[NB_AW-1:0];
      nb_wr_data = nb_rdata;
      priority if (cmd.do_load) begin
         nb_wr_en   = !nb_full;
         nb_wr_addr = nb_count_ff[NB_AW-1:0];
         nb_wr_data = {req_id_ff, req_mass_ff, own_l_ff, own_b_ff, own_r_ff, own_t_ff};
      end else if (cmd.upd_eval) begin
         nb_wr_en   = area_nz;
         nb_wr_addr = keep_ff[NB_AW-1:0];
      end else if (cmd.rm_wr) begin
         nb_wr_en   = 1'b1;
      end
   end

   assign nb_rd_addr = cmd.rm_rd ? idx_next[NB_AW-1:0] : idx_ff[NB_AW-1:0];
   assign met_wr_en  = cmd.do_met && !met_full;

   cnpt_ram #(.WIDTH(ENT_W), .DEPTH(NEIGHBOUR_DEPTH)) u_nb_ram (
      .clock   (clock),
      .wr_en   (nb_wr_en),
      .wr_addr (nb_wr_addr),
      .wr_data (nb_wr_data),
      .rd_en   (cmd.ent_rd || cmd.rm_rd),
      .rd_addr (nb_rd_addr),
      .rd_data (nb_rdata)
   );

   cnpt_ram #(.WIDTH(ID_W), .DEPTH(MET_DEPTH)) u_met_ram (
      .clock   (clock),
      .wr_en   (met_wr_en),
      .wr_addr (met_count_ff[MET_AW-1:0]),
      .wr_data (req_id_ff),
      .rd_en   (cmd.met_rd),
      .rd_addr (met_idx_ff[MET_AW-1:0]),
      .rd_data (met_rdata)
   );

   // control state and architectural registers
   always_ff @(posedge clock) begin
      if (reset) begin
         nb_count_ff  <= '0;
         met_count_ff <= '0;
         best_mass_ff <= '0;
         best_area_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         priority if (cmd.do_clear) begin
            nb_count_ff  <= '0;
            met_count_ff <= '0;
            best_mass_ff <= '0;
            best_area_ff <= '0;
         end else if (cmd.do_load) begin
            if (!nb_full) nb_count_ff <= nb_count_ff + 1'b1;
         end else if (cmd.do_met) begin
            if (!met_full) met_count_ff <= met_count_ff + 1'b1;
         end else if (cmd.upd_init) begin
            best_mass_ff <= '0;
            best_area_ff <= '0;
         end else if (cmd.upd_eval) begin
            if (area_nz) begin
               if (ent_mass > best_mass_ff) begin
                  best_mass_ff <= ent_mass;
                  best_area_ff <= area_ff;
               end else if ((ent_mass == best_mass_ff) && (area_ff > best_area_ff)) begin
                  best_area_ff <= area_ff;
               end
            end
         end else if (cmd.upd_fin) begin
            nb_count_ff <= keep_ff;
         end else if (cmd.rm_fin) begin
            nb_count_ff <= nb_count_ff - 1'b1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_cmd_ff      <= req_command;
         req_id_ff       <= req_item_id;
         req_mass_ff     <= req_mass;
         own_l_ff        <= req_box_left;
         own_b_ff        <= req_box_bottom;
         own_r_ff        <= req_box_right;
         own_t_ff        <= req_box_top;
         picked_id_ff    <= '0;
         picked_valid_ff <= 1'b0;
         status_ff       <= STATUS_OK;
      end
      if (cmd.do_load && nb_full)  status_ff <= STATUS_NB_FULL;
      if (cmd.do_met && met_full)  status_ff <= STATUS_MET_FULL;
      if (cmd.upd_init) begin
         idx_ff  <= '0;
         keep_ff <= '0;
      end
      if (cmd.pick_init) idx_ff <= '0;
      if (cmd.geo) begin
         w_ff        <= w_in;
         h_ff        <= h_in;
         ovl_zero_ff <= ovl_zero_in;
      end
      if (cmd.mul) area_ff <= area_in;
      if (cmd.upd_eval) begin
         idx_ff <= idx_next;
         if (area_nz) keep_ff <= keep_ff + 1'b1;
      end
      if (cmd.pick_eval) begin
         idx_ff <= idx_next;
         if (better) begin
            scan_best_ff <= idx_ff;
            scan_mass_ff <= ent_mass;
            scan_area_ff <= area_ff;
            scan_id_ff   <= ent_id;
         end
      end
      if (cmd.met_init) begin
         met_idx_ff <= '0;
         found_ff   <= 1'b0;
      end
      if (cmd.met_cmp) begin
         met_idx_ff <= met_idx_ff + 1'b1;
         if (met_rdata == scan_id_ff) found_ff <= 1'b1;
      end
      if (cmd.pick_take && !found_ff) begin
         picked_id_ff    <= scan_id_ff;
         picked_valid_ff <= 1'b1;
      end
      if (cmd.rm_init) idx_ff <= scan_best_ff;
      if (cmd.rm_wr)   idx_ff <= idx_next;
      if (cmd.rsp_load) begin
         rsp_picked_id_ff    <= picked_id_ff;
         rsp_picked_valid_ff <= picked_valid_ff;
         rsp_best_mass_ff    <= best_mass_ff;
         rsp_best_area_ff    <= best_area_ff;
         rsp_any_left_ff     <= (nb_count_ff != '0);
         rsp_status_ff       <= status_ff;
      end
   end

   always_comb begin
      sts.req_cmd  = req_cmd_ff;
      sts.scan_end = (idx_ff >= nb_count_ff);
      sts.met_end  = found_ff || (met_idx_ff >= met_count_ff);
      sts.rm_end   = ({1'b0, idx_ff} + 1'b1) >= {1'b0, nb_count_ff};
      sts.nb_empty = (nb_count_ff == '0);
      sts.picked   = picked_valid_ff;
      sts.rsp_busy = rsp_busy;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_picked_id    = rsp_picked_id_ff;
   assign rsp_picked_valid = rsp_picked_valid_ff;
   assign rsp_best_mass    = rsp_best_mass_ff;
   assign rsp_best_area    = rsp_best_area_ff;
   assign rsp_any_left     = rsp_any_left_ff;
   assign rsp_status       = rsp_status_ff;

   `CNPT_ASSERT_NEXT(a_load_grows, cmd.do_load && !nb_full, nb_count_ff == NB_CW'($past(nb_count_ff) + 1'b1), "load did not append")
   `CNPT_ASSERT_IMP(a_compact_order, cmd.upd_eval, keep_ff <= idx_ff, "compaction wrote ahead of scan")
   `CNPT_ASSERT_IMP(a_rsp_no_overwrite, cmd.rsp_load, !rsp_busy, "result overwritten while stalled")

endmodule

[design/collision_neighbor_priority_table_top.sv]
// Top level of the collision neighbor priority table.
// Depends on cnpt_pkg, cnpt_ctrl, cnpt_dp (and through it cnpt_ram).

// One item in, one result item out, one command at a time. Clear, load and
// mark met step through idle, execute and result load. Update reads each
// stored neighbor from the neighbor RAM, forms its overlap box, multiplies
// the area out and saturates it, then keeps the entry (written back at its
// compacted slot) or drops it. Pick runs passes until an entry not yet met
// is found or the table runs empty: each pass scans all entries for the
// best, checks its id against the met ids, and shifts entries down to
// close the removed slot. Entries are handled one after another over the
// one read port of the neighbor RAM and the shared area unit. After the
// last pass the result is loaded into the output register. A new item is
// taken as soon as the sequencer is back in idle, while the previous result
// may still sit in the output register; a finished command waits in its
// last step while an older result is still stalled. No clearing pass after
// reset: only slots below the fill counts are ever read.
module collision_neighbor_priority_table_top
   import cnpt_pkg::*;
#(
   parameter int NEIGHBOUR_DEPTH = NEIGHBOUR_DEPTH_DEF,
   parameter int MET_DEPTH       = MET_DEPTH_DEF,
   parameter int COORD_BITS      = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [CMD_W-1:0]             req_command,
   input  logic [ID_W-1:0]              req_item_id,
   input  logic [MASS_W-1:0]            req_mass,
   input  logic signed [COORD_BITS-1:0] req_box_left,
   input  logic signed [COORD_BITS-1:0] req_box_bottom,
   input  logic signed [COORD_BITS-1:0] req_box_right,
   input  logic signed [COORD_BITS-1:0] req_box_top,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [ID_W-1:0]              rsp_picked_id,
   output logic                         rsp_picked_valid,
   output logic [MASS_W-1:0]            rsp_best_mass,
   output logic [AREA_W-1:0]            rsp_best_area,
   output logic                         rsp_any_left,
   output logic [STATUS_W-1:0]          rsp_status
);

   cnpt_cmd_type cmd;
   cnpt_sts_type sts;

   // sequencer: walks each command through its steps
   cnpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: tables, area unit, best tracking, result register
   cnpt_dp #(
      .NEIGHBOUR_DEPTH (NEIGHBOUR_DEPTH),
      .MET_DEPTH       (MET_DEPTH),
      .COORD_BITS      (COORD_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_command      (req_command),
      .req_item_id      (req_item_id),
      .req_mass         (req_mass),
      .req_box_left     (req_box_left),
      .req_box_bottom   (req_box_bottom),
      .req_box_right    (req_box_right),
      .req_box_top      (req_box_top),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_picked_id    (rsp_picked_id),
      .rsp_picked_valid (rsp_picked_valid),
      .rsp_best_mass    (rsp_best_mass),
      .rsp_best_area    (rsp_best_area),
      .rsp_any_left     (rsp_any_left),
      .rsp_status       (rsp_status)
   );

endmodule
